FILE: hdl/streaming_k_smallest_unit_assert.svh
// Assertion macros for the streaming k-smallest unit.
// Used by the checker bound to the top level; no other dependencies.
`ifndef STREAMING_K_SMALLEST_UNIT_ASSERT_SVH
`define STREAMING_K_SMALLEST_UNIT_ASSERT_SVH

// same-cycle implication
`define SKU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sku_pkg.sv
// Shared types and constants for the streaming k-smallest unit.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package sku_pkg;

  localparam int VALUE_W = 32;
  localparam int KEEP_W  = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_final;
  } item_t;

  typedef enum logic [1:0] {
    BK_COLLECT,
    BK_EMIT,
    BK_SHORT
  } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/sku_stream_if.sv
// Channel interfaces (input, result, configuration) for the k-smallest unit.
// Depends on sku_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sku_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sku_pkg::VALUE_W-1:0] sample_value;
  logic                               is_final;

  modport source (output valid, sample_value, is_final, input ready);
  modport sink   (input valid, sample_value, is_final, output ready);
endinterface

interface sku_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sku_pkg::VALUE_W-1:0] kept_value;
  logic                               run_end;
  logic                               too_few;

  modport source (output valid, kept_value, run_end, too_few, input ready);
  modport sink   (input valid, kept_value, run_end, too_few, output ready);
endinterface

interface sku_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sku_pkg::KEEP_W-1:0]  keep_count;

  modport source (output valid, keep_count, input ready);
  modport sink   (input valid, keep_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/streaming_k_smallest_unit.sv
// Streaming k-smallest selection: a set of signed values goes in, one per cycle,
// and the k smallest come out in ascending order when the final value of the set
// has been taken in. A two-entry queue feeds a sorted store of K_MAX entries
// that inserts one value per cycle through a row of parallel compares, so values
// are accepted at one per cycle while a set is collected. The final value of a
// set leads to k results (a single result when fewer than k values came,
// flagged too_few); during them the store takes no new values and input stalls
// once the queue holds two values. keep_count (k) is clamped to 1..K_MAX and
// must only be written while the block is idle.
// Depends on sku_pkg, sku_stream_if.sv, sku_queue and sku_back.
`timescale 1ns / 1ps
`default_nettype none

module streaming_k_smallest_unit #(
  parameter int K_MAX = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sku_in_if.sink    in_ch,
  sku_out_if.source out_ch,
  sku_cfg_if.sink   cfg_ch
);

  localparam int KW = $clog2(K_MAX + 1);
  localparam int CW = (KW > sku_pkg::KEEP_W) ? KW : sku_pkg::KEEP_W;

  logic [sku_pkg::KEEP_W-1:0] keep_count_r;
  logic [CW-1:0]              keep_ext;
  logic [KW-1:0]              k_eff;
  sku_pkg::item_t             in_item, deq_item;
  logic                       deq_valid, deq_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= sku_pkg::KEEP_W'(1);
    end else if (cfg_ch.valid) begin
      keep_count_r <= cfg_ch.keep_count;
    end
  end

  always_comb begin
    keep_ext = CW'(keep_count_r);
    if (keep_ext == '0) begin
      k_eff = KW'(1);
    end else if (keep_ext > CW'(K_MAX)) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(keep_ext);
    end
  end

  assign in_item.value    = in_ch.sample_value;
  assign in_item.is_final = in_ch.is_final;

  sku_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item)
  );

  sku_back #(
    .K_MAX (K_MAX)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .k              (k_eff),
    .deq_valid      (deq_valid),
    .deq_ready      (deq_ready),
    .deq_item       (deq_item),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kept_value (out_ch.kept_value),
    .out_run_end    (out_ch.run_end),
    .out_too_few    (out_ch.too_few)
  );

endmodule

`default_nettype wire

FILE: hdl/sku_queue.sv
// Front end: accepts input transactions into a two-entry queue.
// Depends on sku_pkg (item_t).
`timescale 1ns / 1ps
`default_nettype none

module sku_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sku_pkg::item_t in_item,
  output logic                deq_valid,
  input  wire logic           deq_ready,
  output sku_pkg::item_t      deq_item
);

  sku_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready  = (count_r != 2'd2);
  assign deq_valid = (count_r != 2'd0);
  assign deq_item  = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sku_back.sv
// Back end: sorted insertion store, too-few check and ascending read-out.
// Depends on sku_pkg (item_t, back_state_t, VALUE_W).
`timescale 1ns / 1ps
`default_nettype none

module sku_back #(
  parameter int K_MAX = 16,
  localparam int KW = $clog2(K_MAX + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [KW-1:0]                      k,
  input  wire logic                               deq_valid,
  output logic                                    deq_ready,
  input  wire sku_pkg::item_t                     deq_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [sku_pkg::VALUE_W-1:0]      out_kept_value,
  output logic                                    out_run_end,
  output logic                                    out_too_few
);

  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  sku_pkg::back_state_t state_r, state_nxt;

  logic signed [sku_pkg::VALUE_W-1:0] store_r   [K_MAX];
  logic signed [sku_pkg::VALUE_W-1:0] store_nxt [K_MAX];
  logic signed [sku_pkg::VALUE_W-1:0] ins       [K_MAX];
  logic [KW-1:0] fill_r, fill_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] f, fb, fin;
  logic [IW-1:0] kidx;
  logic [K_MAX-1:0] gt;
  logic full, take, pop, out_fire, short_set;

  assign pop      = deq_valid && deq_ready;
  assign out_fire = out_valid && out_ready;

  // insertion row
  always_comb begin
    f    = (fill_r > k) ? k : fill_r;
    kidx = IW'(k - KW'(1));
    full = (f == k);
    take = !full || (deq_item.value < store_r[kidx]);
    fb   = full ? (k - KW'(1)) : f;
    fin  = take ? (fb + KW'(1)) : f;
    short_set = (fin < k);
    for (int i = 0; i < K_MAX; i++) begin
      gt[i] = (KW'(i) >= fb) || (store_r[i] > deq_item.value);
    end
    ins[0] = gt[0] ? deq_item.value : store_r[0];
    for (int i = 1; i < K_MAX; i++) begin
      if (!gt[i]) begin
        ins[i] = store_r[i];
      end else if (!gt[i-1]) begin
        ins[i] = deq_item.value;
      end else begin
        ins[i] = store_r[i-1];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sku_pkg::BK_COLLECT: begin
        if (pop && deq_item.is_final) begin
          state_nxt = short_set ? sku_pkg::BK_SHORT : sku_pkg::BK_EMIT;
        end
      end
      sku_pkg::BK_EMIT: begin
        if (out_fire && (cnt_r == '0)) begin
          state_nxt = sku_pkg::BK_COLLECT;
        end
      end
      sku_pkg::BK_SHORT: begin
        if (out_fire) begin
          state_nxt = sku_pkg::BK_COLLECT;
        end
      end
      default: state_nxt = sku_pkg::BK_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    deq_ready      = 1'b0;
    out_valid      = 1'b0;
    out_kept_value = '0;
    out_run_end    = 1'b0;
    out_too_few    = 1'b0;
    case (state_r)
      sku_pkg::BK_COLLECT: begin
        deq_ready = 1'b1;
      end
      sku_pkg::BK_EMIT: begin
        out_valid      = 1'b1;
        out_kept_value = store_r[0];
        out_run_end    = (cnt_r == '0);
      end
      sku_pkg::BK_SHORT: begin
        out_valid   = 1'b1;
        out_run_end = 1'b1;
        out_too_few = 1'b1;
      end
      default: begin
        deq_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    store_nxt = store_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    if (state_r == sku_pkg::BK_COLLECT && pop) begin
      fill_nxt = fin;
      if (take) begin
        store_nxt = ins;
      end
      if (deq_item.is_final) begin
        fill_nxt = '0;
        cnt_nxt  = k - KW'(1);
      end
    end else if (state_r == sku_pkg::BK_EMIT && out_fire) begin
      for (int i = 0; i < K_MAX - 1; i++) begin
        store_nxt[i] = store_r[i+1];
      end
      cnt_nxt = cnt_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sku_pkg::BK_COLLECT;
      fill_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/sku_checker.sv
// Port-level assertions for the streaming k-smallest unit, bound to the top.
// Depends on sku_pkg and streaming_k_smallest_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "streaming_k_smallest_unit_assert.svh"

module sku_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [sku_pkg::VALUE_W-1:0] out_kept_value,
  input wire logic                               out_run_end,
  input wire logic                               out_too_few
);

  logic                          stall;
  logic                          short_res;
  logic [sku_pkg::VALUE_W+1:0]   out_word;

  assign stall     = out_valid && !out_ready;
  assign short_res = out_valid && out_too_few;
  assign out_word  = {out_kept_value, out_run_end, out_too_few};

  // a too-few transaction stands alone and closes its run
  `SKU_ASSERT_NOW(a_short_ends_run, clk, rst_n, short_res, out_run_end, "too_few without run_end")

  `SKU_ASSERT_NOW(a_short_zero, clk, rst_n, short_res, out_kept_value == '0, "too_few with value")

  `SKU_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(out_word), "result moved")

endmodule

bind streaming_k_smallest_unit sku_checker u_sku_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kept_value (out_ch.kept_value),
  .out_run_end    (out_ch.run_end),
  .out_too_few    (out_ch.too_few)
);

`default_nettype wire
